FILE: hdl/hsv2rgb_pkg.sv
// Shared types, constants and helpers for the HSV to RGB pixel pipeline.
`default_nettype none

package hsv2rgb_pkg;

  // Hue sectors, hue * 6 >> 16
  localparam logic [2:0] SECT_RED_YEL = 3'd0;
  localparam logic [2:0] SECT_YEL_GRN = 3'd1;
  localparam logic [2:0] SECT_GRN_CYN = 3'd2;
  localparam logic [2:0] SECT_CYN_BLU = 3'd3;
  localparam logic [2:0] SECT_BLU_MAG = 3'd4;

  localparam int unsigned FracBits = 16;
  // 255 * 2^16, full-scale numerator of the q/t levels
  localparam logic [23:0] LevelFull = 24'd16711680;
  localparam logic [16:0] FracOne   = 17'h10000;
  localparam logic [7:0]  ByteFull  = 8'd255;

  typedef struct packed {
    logic [18:0] h6;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [15:0] pp;    // val * (255 - sat)
  } stage1_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [23:0] fq;    // f * sat
    logic [23:0] ft;    // (1 - f) * sat
    logic [7:0]  lp;
    logic [7:0]  val;
  } stage2_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [15:0] xq;    // val * (255*2^16 - f*sat) >> 16
    logic [15:0] xt;
    logic [7:0]  lp;
    logic [7:0]  val;
  } stage3_t;

  // floor(x / 255), exact for x < 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/hsv2rgb_front.sv
// Stages one and two: hue times six, p product, the f*s products and the p divide by 255.
`default_nettype none

module hsv2rgb_front (
  input  wire logic                 clk_i,
  input  wire logic                 en1_i,
  input  wire logic                 en2_i,
  input  wire logic [15:0]          hue_i,
  input  wire logic [7:0]           saturation_i,
  input  wire logic [7:0]           brightness_i,
  output hsv2rgb_pkg::stage2_t      st2_o
);

  hsv2rgb_pkg::stage1_t st1_d, st1_q;
  hsv2rgb_pkg::stage2_t st2_d, st2_q;
  logic [15:0] frac;
  logic [16:0] frac_inv;
  logic [24:0] ft_full;

  // stage 1
  always_comb begin
    st1_d.h6  = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};
    st1_d.sat = saturation_i;
    st1_d.val = brightness_i;
    st1_d.pp  = {8'b0, brightness_i} * {8'b0, hsv2rgb_pkg::ByteFull - saturation_i};
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      st1_q <= st1_d;
    end
  end

  // stage 2
  always_comb begin
    frac          = st1_q.h6[hsv2rgb_pkg::FracBits-1:0];
    frac_inv      = hsv2rgb_pkg::FracOne - {1'b0, frac};
    ft_full       = {8'b0, frac_inv} * {17'b0, st1_q.sat};
    st2_d.sector  = st1_q.h6[18:16];
    st2_d.fq      = {8'b0, frac} * {16'b0, st1_q.sat};
    st2_d.ft      = ft_full[23:0];
    st2_d.lp      = hsv2rgb_pkg::div255(st1_q.pp);
    st2_d.val     = st1_q.val;
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      st2_q <= st2_d;
    end
  end

  assign st2_o = st2_q;

endmodule

`default_nettype wire

FILE: hdl/hsv2rgb_level.sv
// Stage three: scales the q and t numerators by value.
`default_nettype none

module hsv2rgb_level (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire hsv2rgb_pkg::stage2_t st2_i,
  output hsv2rgb_pkg::stage3_t      st3_o
);

  hsv2rgb_pkg::stage3_t st3_d, st3_q;
  logic [23:0] dq, dt;
  logic [31:0] nq, nt;

  always_comb begin
    dq = hsv2rgb_pkg::LevelFull - st2_i.fq;
    dt = hsv2rgb_pkg::LevelFull - st2_i.ft;
    nq = {24'b0, st2_i.val} * {8'b0, dq};
    nt = {24'b0, st2_i.val} * {8'b0, dt};
    st3_d.sector = st2_i.sector;
    st3_d.xq     = nq[31:16];
    st3_d.xt     = nt[31:16];
    st3_d.lp     = st2_i.lp;
    st3_d.val    = st2_i.val;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st3_q <= st3_d;
    end
  end

  assign st3_o = st3_q;

endmodule

`default_nettype wire

FILE: hdl/hsv2rgb_out.sv
// Stage four: final divide by 255, sector mapping and RGB565 packing.
`default_nettype none

module hsv2rgb_out (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire hsv2rgb_pkg::stage3_t st3_i,
  output logic [7:0]                red_o,
  output logic [7:0]                green_o,
  output logic [7:0]                blue_o,
  output logic [15:0]               packed_565_o
);

  logic [7:0] lq, lt, lp, lv;
  logic [7:0] red_d, green_d, blue_d;
  logic [7:0] red_q, green_q, blue_q;

  always_comb begin
    lq = hsv2rgb_pkg::div255(st3_i.xq);
    lt = hsv2rgb_pkg::div255(st3_i.xt);
    lp = st3_i.lp;
    lv = st3_i.val;
    unique case (st3_i.sector)
      hsv2rgb_pkg::SECT_RED_YEL: begin red_d = lv; green_d = lt; blue_d = lp; end
      hsv2rgb_pkg::SECT_YEL_GRN: begin red_d = lq; green_d = lv; blue_d = lp; end
      hsv2rgb_pkg::SECT_GRN_CYN: begin red_d = lp; green_d = lv; blue_d = lt; end
      hsv2rgb_pkg::SECT_CYN_BLU: begin red_d = lp; green_d = lq; blue_d = lv; end
      hsv2rgb_pkg::SECT_BLU_MAG: begin red_d = lt; green_d = lp; blue_d = lv; end
      default:                   begin red_d = lv; green_d = lp; blue_d = lq; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign packed_565_o = {red_q[7:3], green_q[7:2], blue_q[7:3]};

endmodule

`default_nettype wire

FILE: hdl/hsv_to_rgb_pixel_unit.sv
// Top level of the HSV to RGB pixel converter: four-stage pipeline and handshake control.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | hue_i, saturation_i, brightness_i
//   out     | output    | out_valid_o / out_stall_i| red_o, green_o, blue_o, packed_565_o
//
// Items pass four register stages (products, f*s, value scaling, divide and mapping) in
// order to out_valid_o; one item per cycle sustained while out_stall_i stays low.
// Reset only clears the stage valid bits; payload registers are not reset.
// A stall holds the full stages in place; empty stages still fill, so bubbles collapse.
// in_stall_o rises only when every stage holds an item and the output is stalled.
`default_nettype none

module hsv_to_rgb_pixel_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] hue_i,
  input  wire logic [7:0]  saturation_i,
  input  wire logic [7:0]  brightness_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [15:0]      packed_565_o
);

  // valid bits for each stage; v4 is the output register
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic en1, en2, en3, en4;

  hsv2rgb_pkg::stage2_t st2;
  hsv2rgb_pkg::stage3_t st3;

  // a stage loads when it is empty or its contents move on
  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o  = !en1;
  assign out_valid_o = v4_q;

  always_comb begin
    v1_d = en1 ? in_valid_i : v1_q;
    v2_d = en2 ? v1_q : v2_q;
    v3_d = en3 ? v2_q : v3_q;
    v4_d = en4 ? v3_q : v4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  hsv2rgb_front u_front (
    .clk_i        (clk_i),
    .en1_i        (en1),
    .en2_i        (en2),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .st2_o        (st2)
  );

  hsv2rgb_level u_level (
    .clk_i (clk_i),
    .en_i  (en3),
    .st2_i (st2),
    .st3_o (st3)
  );

  hsv2rgb_out u_out (
    .clk_i        (clk_i),
    .en_i         (en4),
    .st3_i        (st3),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .packed_565_o (packed_565_o)
  );

  // backpressure reaches the input only with the whole pipe full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_stall_i))
    else $error("input stalled with an empty stage");

  // an item leaving stage three lands in the output register
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4) |=> out_valid_o)
    else $error("item lost between stage three and output");

  // an empty output register never blocks the input
  a_bubble_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output is empty");

endmodule

`default_nettype wire

FILE: tb/hsv_to_rgb_pixel_checker.sv
// Pixel converter checker: predicts RGB bytes and RGB565 words and compares them with the outputs.
module hsv_to_rgb_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  brightness_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [15:0] packed_565_i,
  input  logic        wrap_up_i,
  output int          pending_o,
  output int          fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxShown = 100;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] rgb565;
  } rgb_pixel_t;

  rgb_pixel_t expected_pixels[$];
  int         mismatches = 0;
  int         shown      = 0;
  bit         leftovers_counted = 1'b0;

  // floor(val * (255*2^16 - frac*sat) / (255*2^16)), frac in 0..2^16
  function automatic logic [7:0] scaled_level(logic [7:0] val, logic [7:0] sat,
                                              logic [16:0] frac);
    longint unsigned full;
    longint unsigned num;
    full = 64'd255 * 64'd65536;
    num  = full - longint'(frac) * longint'(sat);
    return 8'((longint'(val) * num) / full);
  endfunction

  function automatic rgb_pixel_t convert_pixel(logic [15:0] hue, logic [7:0] sat,
                                               logic [7:0] val);
    logic [18:0] turn6;
    logic [2:0]  sector;
    logic [16:0] frac;
    logic [7:0]  lvl_p, lvl_q, lvl_t;
    rgb_pixel_t  px;
    turn6  = {3'b000, hue} * 19'd6;
    sector = turn6[18:16];
    frac   = {1'b0, turn6[15:0]};
    lvl_p  = 8'((int'(val) * (255 - int'(sat))) / 255);
    lvl_q  = scaled_level(val, sat, frac);
    lvl_t  = scaled_level(val, sat, 17'h10000 - frac);
    case (sector)
      hsv2rgb_pkg::SECT_RED_YEL: begin px.red = val;   px.green = lvl_t; px.blue = lvl_p; end
      hsv2rgb_pkg::SECT_YEL_GRN: begin px.red = lvl_q; px.green = val;   px.blue = lvl_p; end
      hsv2rgb_pkg::SECT_GRN_CYN: begin px.red = lvl_p; px.green = val;   px.blue = lvl_t; end
      hsv2rgb_pkg::SECT_CYN_BLU: begin px.red = lvl_p; px.green = lvl_q; px.blue = val;   end
      hsv2rgb_pkg::SECT_BLU_MAG: begin px.red = lvl_t; px.green = lvl_p; px.blue = val;   end
      default:                   begin px.red = val;   px.green = lvl_p; px.blue = lvl_q; end
    endcase
    px.rgb565 = {px.red[7:3], px.green[7:2], px.blue[7:3]};
    return px;
  endfunction

  task automatic report_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (shown < MaxShown) begin
        shown++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_pixel_t want;
    if (!rst_ni) begin
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (shown < MaxShown) begin
            shown++;
            $display("%0t: result with none expected, actual r=%0d g=%0d b=%0d 565=%04h",
                     $time, red_i, green_i, blue_i, packed_565_i);
          end
        end else begin
          want = expected_pixels.pop_front();
          report_field("red", want.red, red_i);
          report_field("green", want.green, green_i);
          report_field("blue", want.blue, blue_i);
          report_field("packed_565", want.rgb565, packed_565_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_pixels.push_back(convert_pixel(hue_i, saturation_i, brightness_i));
      if (wrap_up_i && !leftovers_counted) begin
        leftovers_counted = 1'b1;
        if (expected_pixels.size() != 0) begin
          mismatches += expected_pixels.size();
          $display("%0t: %0d expected results never arrived, expected %0d actual 0",
                   $time, expected_pixels.size(), expected_pixels.size());
        end
      end
      pending_o    <= expected_pixels.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: tb/tb_hsv_to_rgb_pixel_unit.sv
// Testbench top for the HSV to RGB pixel converter: clock, reset, pixel stimulus and verdict.
module tb_hsv_to_rgb_pixel_unit;

  timeunit 1ns;
  timeprecision 1ps;

  // Run limit in clock cycles. The slowest correct run is 1220 items, each with
  // a long sender gap and a long receiver stall, plus the deliberate hold-offs
  // and a few drains; this is several times that.
  localparam int CycleLimit = 600000;
  // Receiver hold-off long enough to fill all four pipeline stages.
  localparam int LongHold   = 80;
  // Extra settling at the end, after the last result has come back.
  localparam int TailCycles = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] hue_i;
  logic [7:0]  saturation_i;
  logic [7:0]  brightness_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [15:0] packed_565_o;

  logic        wrap_up;
  int          pending_pixels;
  int          fail_count;
  int          cycle_count = 0;

  // Idle controls for the sender (tx_idle_on) and the receiver (rx_idle_on, hold_req).
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_req   = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hsv_to_rgb_pixel_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .packed_565_o (packed_565_o)
  );

  hsv_to_rgb_pixel_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_i        (red_o),
    .green_i      (green_o),
    .blue_i       (blue_o),
    .packed_565_i (packed_565_o),
    .wrap_up_i    (wrap_up),
    .pending_o    (pending_pixels),
    .fail_count_o (fail_count)
  );

  // Idle length: a long stretch one time in sixteen, else a short run.
  function automatic int idle_len();
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offer one item; the payload holds until the item is taken (stall low at an edge).
  // valid is only lowered when a gap is inserted, so it never drops and rises in one step.
  task automatic push_pixel(logic [15:0] hue, logic [7:0] sat, logic [7:0] val);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    hue_i        <= hue;
    saturation_i <= sat;
    brightness_i <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Random pixel; saturation and value hit their ends now and then,
  // since zero saturation (grey) and full scale are the interesting corners.
  task automatic push_random_pixel();
    logic [7:0] sat;
    logic [7:0] val;
    sat = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                      : 8'($urandom_range(0, 255));
    val = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                      : 8'($urandom_range(0, 255));
    push_pixel(16'($urandom_range(0, 65535)), sat, val);
  endtask

  // Sender pauses until every expected result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels != 0);
  endtask

  // Receiver: random stall runs, or a long counted hold-off on request.
  initial begin
    int  stall_run;
    bit  stall_level;
    stall_run   = 0;
    stall_level = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_req  = 1'b0;
        stall_run = 0;
      end else begin
        if (stall_run == 0) begin
          stall_level = rx_idle_on && ($urandom_range(0, 2) == 0);
          stall_run   = idle_len();
        end
        stall_run--;
        out_stall_i <= stall_level;
      end
    end
  end

  // Watchdog: a hang or a lost handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    hue_i        = 16'h0000;
    saturation_i = 8'h00;
    brightness_i = 8'h00;
    wrap_up      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners, back to back: hue ends, both sides of every sector
    // boundary, grey (zero saturation), black, full saturation and value.
    push_pixel(16'd0,     8'd255, 8'd255);
    push_pixel(16'd65535, 8'd255, 8'd255);
    push_pixel(16'd0,     8'd0,   8'd255);
    push_pixel(16'd40000, 8'd0,   8'd137);
    push_pixel(16'd12345, 8'd200, 8'd0);
    push_pixel(16'd10922, 8'd255, 8'd255);
    push_pixel(16'd10923, 8'd255, 8'd255);
    push_pixel(16'd21845, 8'd255, 8'd200);
    push_pixel(16'd21846, 8'd255, 8'd200);
    push_pixel(16'd32767, 8'd128, 8'd255);
    push_pixel(16'd32768, 8'd128, 8'd255);
    push_pixel(16'd43690, 8'd255, 8'd255);
    push_pixel(16'd43691, 8'd255, 8'd255);
    push_pixel(16'd54613, 8'd1,   8'd255);
    push_pixel(16'd54614, 8'd254, 8'd255);
    push_pixel(16'd5461,  8'd255, 8'd1);
    push_pixel(16'd27306, 8'd77,  8'd254);
    push_pixel(16'd60074, 8'd170, 8'd85);
    push_pixel(16'hAAAA,  8'h55,  8'hAA);
    push_pixel(16'h5555,  8'hAA,  8'h55);
    wait_drained();

    // Idling on both sides; a long receiver hold-off fills the pipeline
    // while items keep coming, and a sender pause drains it.
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int n = 0; n < 400; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 250) wait_drained();
      push_random_pixel();
    end

    // Full rate both ways.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int n = 0; n < 300; n++) push_random_pixel();

    // Mixed idling: sender gaps only, receiver stalls only, then both.
    tx_idle_on = 1'b1;
    for (int n = 0; n < 150; n++) push_random_pixel();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    for (int n = 0; n < 150; n++) push_random_pixel();
    tx_idle_on = 1'b1;
    for (int n = 0; n < 200; n++) begin
      if (n == 100) begin
        hold_req = 1'b1;
        wait_drained();
      end
      push_random_pixel();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk_i);

    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
hdl/hsv2rgb_pkg.sv
hdl/hsv2rgb_front.sv
hdl/hsv2rgb_level.sv
hdl/hsv2rgb_out.sv
hdl/hsv_to_rgb_pixel_unit.sv
tb/hsv_to_rgb_pixel_checker.sv
tb/tb_hsv_to_rgb_pixel_unit.sv
